@@ src/sdc_pkg.sv @@
// Shared types, constants and the CRC-32 byte update for the SLIP deframer.
// No dependencies; every other file of the block imports this package.
package sdc_pkg;

  // Largest frame, in decoded bytes including the four CRC bytes.
  localparam int MaxFrameBytes = 512;
  localparam int CntW          = $clog2(MaxFrameBytes + 1);
  localparam int LenW          = 9;
  localparam int SumW          = (CntW > LenW) ? CntW : LenW;
  localparam int CrcBytes      = 4;

  localparam logic [7:0] SlipEnd    = 8'hC0;
  localparam logic [7:0] SlipEsc    = 8'hDB;
  localparam logic [7:0] SlipEscEnd = 8'hDC;
  localparam logic [7:0] SlipEscEsc = 8'hDD;

  localparam logic [31:0] CrcPoly = 32'hEDB88320;
  localparam logic [31:0] CrcInit = 32'hFFFFFFFF;

  localparam logic KindPayload = 1'b0;
  localparam logic KindVerdict = 1'b1;

  typedef struct packed {
    logic            kind;
    logic [7:0]      payload_byte;
    logic            frame_ok;
    logic            overflow;
    logic [LenW-1:0] payload_len;
  } res_t;

  // Reflected CRC-32 update by one byte, unrolled over its eight bits.
  function automatic logic [31:0] crc32_fold(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ src/slip_deframer_crc32_check.sv @@
// Top level of the SLIP deframer with CRC-32 check.
// Depends on sdc_pkg, sdc_frame and sdc_out_reg.
//
// The input channel takes one raw serial byte per word (in_valid_i, in_stall_o,
// rx_byte_i). The output channel gives zero or one result word per input word:
// either a decoded payload byte (result_kind_o low) or an end-of-frame verdict
// (result_kind_o high) with frame_ok_o, overflow_o and payload_len_o.
// Payload bytes leave four bytes behind the line, so the trailing CRC is never
// sent on as payload; the consumer discards a frame whose verdict is not ok.
// Frames of four decoded bytes or fewer end silently, without a verdict.
// A frame longer than MaxFrameBytes drops its surplus bytes and is flagged.
// A result caused by the word accepted at one edge is visible on the output
// from that edge onwards. Throughput is one word per cycle while the output is
// not stalled, set by the single result register, which is reloaded in the cycle it
// is taken. While a result is held by out_stall_i, in_stall_o is raised and
// the held word stays unchanged; no input word is lost.
// Reset (rst_ni low, asynchronous) empties the result register and clears the
// frame state: no escape pending, zero count, CRC all ones, no overflow.
module slip_deframer_crc32_check (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [7:0]               rx_byte_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     result_kind_o,
  output logic [7:0]               payload_byte_o,
  output logic                     frame_ok_o,
  output logic                     overflow_o,
  output logic [sdc_pkg::LenW-1:0] payload_len_o
);
  import sdc_pkg::*;

  logic accept;
  logic res_load;
  res_t res_new;
  res_t res_held;

  // The result register is busy only while it holds a word the receiver refuses.
  assign in_stall_o = out_valid_o && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  sdc_frame u_frame (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .rx_byte_i  (rx_byte_i),
    .res_load_o (res_load),
    .res_o      (res_new)
  );

  sdc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_load),
    .res_i       (res_new),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (res_held)
  );

  assign result_kind_o  = res_held.kind;
  assign payload_byte_o = res_held.payload_byte;
  assign frame_ok_o     = res_held.frame_ok;
  assign overflow_o     = res_held.overflow;
  assign payload_len_o  = res_held.payload_len;

endmodule

@@ src/sdc_frame.sv @@
// Frame state of the deframer: escape decoding, four-byte tail line, byte count and CRC.
// Depends on sdc_pkg for constants, the result struct and the CRC byte update.
module sdc_frame (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    rx_byte_i,
  output logic          res_load_o,
  output sdc_pkg::res_t res_o
);
  import sdc_pkg::*;

  logic            esc_q, esc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [31:0]     crc_q, crc_d;
  logic            ovf_q, ovf_d;
  logic [7:0]      tail_q [4];
  logic [7:0]      tail_d [4];

  logic            have_data;
  logic [7:0]      dec_byte;
  logic [31:0]     recv_crc;
  logic [SumW-1:0] len_full;

  assign recv_crc = {tail_q[3], tail_q[2], tail_q[1], tail_q[0]};
  assign len_full = SumW'(cnt_q) - SumW'(CrcBytes);

  always_comb begin
    esc_d      = esc_q;
    cnt_d      = cnt_q;
    crc_d      = crc_q;
    ovf_d      = ovf_q;
    tail_d     = tail_q;
    have_data  = 1'b0;
    dec_byte   = rx_byte_i;
    res_load_o = 1'b0;
    res_o      = '0;
    if (accept_i) begin
      if (esc_q) begin
        esc_d     = 1'b0;
        have_data = 1'b1;
        if (rx_byte_i == SlipEscEnd) begin
          dec_byte = SlipEnd;
        end else if (rx_byte_i == SlipEscEsc) begin
          dec_byte = SlipEsc;
        end
      end else if (rx_byte_i == SlipEnd) begin
        if (cnt_q > CntW'(CrcBytes)) begin
          res_load_o        = 1'b1;
          res_o.kind        = KindVerdict;
          res_o.frame_ok    = (~crc_q == recv_crc) && !ovf_q;
          res_o.overflow    = ovf_q;
          res_o.payload_len = len_full[LenW-1:0];
        end
        esc_d = 1'b0;
        cnt_d = '0;
        crc_d = CrcInit;
        ovf_d = 1'b0;
      end else if (rx_byte_i == SlipEsc) begin
        esc_d = 1'b1;
      end else begin
        have_data = 1'b1;
      end

      if (have_data) begin
        if (cnt_q >= CntW'(MaxFrameBytes)) begin
          ovf_d = 1'b1;
        end else if (cnt_q < CntW'(CrcBytes)) begin
          tail_d[cnt_q[1:0]] = dec_byte;
          cnt_d              = cnt_q + CntW'(1);
        end else begin
          tail_d[0]          = tail_q[1];
          tail_d[1]          = tail_q[2];
          tail_d[2]          = tail_q[3];
          tail_d[3]          = dec_byte;
          cnt_d              = cnt_q + CntW'(1);
          crc_d              = crc32_fold(crc_q, tail_q[0]);
          res_load_o         = 1'b1;
          res_o.kind         = KindPayload;
          res_o.payload_byte = tail_q[0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= 1'b0;
      cnt_q <= '0;
      crc_q <= CrcInit;
      ovf_q <= 1'b0;
    end else begin
      esc_q <= esc_d;
      cnt_q <= cnt_d;
      crc_q <= crc_d;
      ovf_q <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tail_q <= tail_d;
  end

endmodule

@@ src/sdc_out_reg.sv @@
// Result register of the deframer: holds one result word until the receiver takes it.
// Depends on sdc_pkg for the result struct.
module sdc_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  sdc_pkg::res_t res_i,
  input  logic          out_stall_i,
  output logic          out_valid_o,
  output sdc_pkg::res_t res_o
);
  import sdc_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

@@ src/sdc_checker.sv @@
// Port-level checks for the SLIP deframer, bound to its top level.
// Depends on sdc_pkg and on slip_deframer_crc32_check.
module sdc_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic                     result_kind_o,
  input logic [7:0]               payload_byte_o,
  input logic                     frame_ok_o,
  input logic                     overflow_o,
  input logic [sdc_pkg::LenW-1:0] payload_len_o
);
  import sdc_pkg::*;

  a_hold_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word withdrawn while stalled");

  a_hold_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(result_kind_o) && $stable(payload_byte_o)
      && $stable(frame_ok_o) && $stable(overflow_o) && $stable(payload_len_o))
    else $error("result word changed while stalled");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a refused result word");

  a_ok_no_ovf : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == KindVerdict |-> !(frame_ok_o && overflow_o))
    else $error("verdict reports ok for an overflowed frame");

  a_payload_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == KindPayload
      |-> !frame_ok_o && !overflow_o && payload_len_o == '0)
    else $error("payload word carries verdict fields");

endmodule

bind slip_deframer_crc32_check sdc_checker u_sdc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .result_kind_o  (result_kind_o),
  .payload_byte_o (payload_byte_o),
  .frame_ok_o     (frame_ok_o),
  .overflow_o     (overflow_o),
  .payload_len_o  (payload_len_o)
);
